[design/bgr_pkg.sv]
// bgr_pkg: shared constants for the byte group reverser.
// Used by byte_group_reverser; depends on nothing.
package bgr_pkg;

	localparam int BYTE_W         = 8;   // width of one string byte
	localparam int CFG_W          = 7;   // width of the group size register
	localparam int MAX_GROUP_DEF  = 64;  // default group buffer depth
	localparam int GROUP_SIZE_RST = 2;   // group size after reset
	localparam int GROUP_SIZE_MIN = 2;   // smallest group size that takes effect

endpackage

[design/bgr_ram.sv]
// bgr_ram: generic single-write, single-read RAM with a registered read port.
// Read data holds while no read is issued. No dependencies.
module bgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/byte_group_reverser.sv]
// A byte that completes a group (or ends the string) starts a run that is read from the
// buffer RAM into the read stage and then the output register, then streams at one beat
// per cycle unless stalled. A byte that emits nothing does not hold the input; one that
// emits a run holds it until the run's last read, set by the single read port of the RAM.
// Reset (arst_n low): fill count and pipeline clear, group size returns to 2; the buffer
// RAM is not cleared, since only entries written in the current group are ever read.
module byte_group_reverser #(
	parameter int MAX_GROUP = bgr_pkg::MAX_GROUP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration: group size
	input  logic                      cfg_wen,
	input  logic [bgr_pkg::CFG_W-1:0] cfg_wdata,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [bgr_pkg::BYTE_W-1:0] in_byte,
	input  logic                      in_last,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bgr_pkg::BYTE_W-1:0] out_byte,
	output logic                      run_last,
	output logic                      string_end
);

	// AW addresses the buffer; CW holds counts up to MAX_GROUP inclusive.
	localparam int AW = $clog2(MAX_GROUP);
	localparam int CW = $clog2(MAX_GROUP + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                     state_q;
	logic [bgr_pkg::CFG_W-1:0]  group_size_q;
	logic [CW-1:0]              fill_q;     // bytes gathered in the current group
	logic [CW-1:0]              cnt_q;      // length of the run being emitted
	logic [CW-1:0]              idx_q;      // next run position to read
	logic                       rev_q;      // run is a full group, read it backward
	logic                       last_q;     // run ends the string

	// Read stage: RAM read data plus the flags that travel with it.
	logic                       s1_valid_q;
	logic                       s1_run_last_q;
	logic                       s1_end_q;

	// Output register.
	logic                       out_valid_q;
	logic [bgr_pkg::BYTE_W-1:0] out_byte_q;
	logic                       run_last_q;
	logic                       string_end_q;

	logic [CW-1:0]              eff_k;
	logic [CW-1:0]              n_next;
	logic                       in_beat;
	logic                       ram_we;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [bgr_pkg::BYTE_W-1:0] ram_rdata;
	logic                       move_s1;
	logic                       read_is_final;
	logic                       start_rev;
	logic                       start_fwd;

	// Clamp the group size register to the range that takes effect.
	always_comb begin
		if (int'(group_size_q) < bgr_pkg::GROUP_SIZE_MIN) begin
			eff_k = CW'(bgr_pkg::GROUP_SIZE_MIN);
		end else if (int'(group_size_q) > MAX_GROUP) begin
			eff_k = CW'(MAX_GROUP);
		end else begin
			eff_k = CW'(group_size_q);
		end
	end

	// Accept a beat only between runs; the RAM read port belongs to the run.
	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;

	// Write the byte at the fill position unless the buffer is full.
	assign ram_we = in_beat && (int'(fill_q) < MAX_GROUP);
	assign n_next = ram_we ? (fill_q + CW'(1)) : fill_q;

	// A full group goes out reversed; a short tail at string end goes out in order.
	assign start_rev = in_beat && (n_next >= eff_k);
	assign start_fwd = in_beat && !(n_next >= eff_k) && in_last;

	// Advance the read stage when the output register is empty or being drained.
	assign move_s1 = s1_valid_q && (!out_valid_q || !out_stall);

	// Issue one read per cycle while the read stage can take its data.
	assign ram_re        = (state_q == ST_EMIT) && (!s1_valid_q || move_s1);
	assign read_is_final = (idx_q == (cnt_q - CW'(1)));
	assign ram_raddr     = rev_q ? AW'(cnt_q - CW'(1) - idx_q) : AW'(idx_q);

	bgr_ram #(
		.WIDTH (bgr_pkg::BYTE_W),
		.DEPTH (MAX_GROUP)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(fill_q)),
		.wdata (in_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state, sequencer and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			group_size_q <= bgr_pkg::CFG_W'(bgr_pkg::GROUP_SIZE_RST);
			fill_q       <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			rev_q        <= 1'b0;
			last_q       <= 1'b0;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				group_size_q <= cfg_wdata;
			end

			case (state_q)
				ST_IDLE: begin
					if (start_rev || start_fwd) begin
						// Latch the run and restart gathering.
						state_q <= ST_EMIT;
						cnt_q   <= n_next;
						idx_q   <= '0;
						rev_q   <= start_rev;
						last_q  <= in_last;
						fill_q  <= '0;
					end else if (in_beat) begin
						fill_q <= n_next;
					end
				end
				ST_EMIT: begin
					if (ram_re) begin
						idx_q <= idx_q + CW'(1);
						if (read_is_final) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Hold the read stage until its data moves on.
			if (ram_re) begin
				s1_valid_q <= 1'b1;
			end else if (move_s1) begin
				s1_valid_q <= 1'b0;
			end

			// Hold the output beat while stalled, drop it once taken.
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: flags of the read in flight and the output beat.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			s1_run_last_q <= read_is_final;
			s1_end_q      <= read_is_final && last_q;
		end
		if (move_s1) begin
			out_byte_q   <= ram_rdata;
			run_last_q   <= s1_run_last_q;
			string_end_q <= s1_end_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

`ifndef SYNTHESIS
	// Gathering never runs past the buffer.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) < MAX_GROUP)
		else $error("fill count reached buffer depth");

	// Every read issued lands in the read stage on the next edge.
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> s1_valid_q)
		else $error("issued read lost");

	// Starting a run empties the gather count.
	a_run_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(start_rev || start_fwd) |=> (fill_q == '0) && (state_q == ST_EMIT))
		else $error("run start did not reset fill count");

	// A string end beat always closes its run.
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && string_end_q) |-> run_last_q)
		else $error("string end without run end");

	// No read is issued with an empty run.
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (cnt_q != '0) && (idx_q < cnt_q))
		else $error("read outside the run");
`endif

endmodule
